// ----- rtl/ubds_pkg.sv -----
package ubds_pkg;

    localparam int CLOCK_W = 31;
    localparam int BAUD_W = 24;
    localparam int OSR_W = 5;
    localparam int DIV_OUT_W = 12;
    localparam int DIVISOR_BITS_DEFAULT = 12;
    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 31'd48000000;
    localparam logic [OSR_W-1:0] OSR_FIRST = 5'd3;
    localparam logic [OSR_W-1:0] OSR_LAST = 5'd31;
    localparam int QUEUE_DEPTH = 2;

    // Request as handed from the front part to the search engine.
    typedef struct packed {
        logic [BAUD_W-1:0]  baud;
        logic [CLOCK_W-1:0] clk;
    } ubds_req_t;

endpackage

// ----- rtl/ubds_front.sv -----
module ubds_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [30:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [23:0]           s_baud_rate,
    output logic                  q_valid,
    input  logic                  q_ready,
    output ubds_pkg::ubds_req_t   q_req
);
    import ubds_pkg::*;

    logic [CLOCK_W-1:0] clock_reg;
    ubds_req_t          slot_reg [QUEUE_DEPTH];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push, pop;

    assign s_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_req   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg <= CLOCK_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (cfg_we) begin
                clock_reg <= cfg_wdata;
            end
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // The clock is captured with each request, so a later write cannot disturb it.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{baud: s_baud_rate, clk: clock_reg};
        end
    end

    count_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
    no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step");
endmodule

// ----- rtl/ubds_divider.sv -----
module ubds_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [35:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [30:0] quotient
);
    logic [30:0] quo_reg;
    logic [36:0] rem_reg;
    logic [35:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [36:0] trial;

    assign trial = {rem_reg[35:0], quo_reg[30]} - {1'b0, den_reg};

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == 5'd0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 5'd30;
            end else if (busy_reg) begin
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[36]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[29:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[35:0], quo_reg[30]};
                quo_reg <= {quo_reg[29:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- rtl/ubds_search.sv -----
module ubds_search #(
    parameter int DIVISOR_BITS = ubds_pkg::DIVISOR_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ubds_pkg::ubds_req_t  q_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [4:0]           m_oversample,
    output logic [11:0]          m_divisor,
    output logic                 m_both_edge,
    output logic [30:0]          m_rate_error,
    output logic                 m_failed
);
    import ubds_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV1  = 5'b00010,
        S_DIV2  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    ubds_req_t req_reg;
    logic [OSR_W-1:0] osr_reg;
    logic [CLOCK_W-1:0] div_reg, ach_reg;
    logic found_reg;
    logic [OSR_W-1:0] best_osr_reg;
    logic [DIVISOR_BITS-1:0] best_div_reg;
    logic [CLOCK_W-1:0] best_err_reg;
    logic [5:0] ratio;
    logic [29:0] bmul;
    logic [35:0] dv_den;
    logic dv_start, dv_busy, dv_done;
    logic [30:0] dv_q;
    logic [30:0] err;
    logic [35:0] dmul;
    logic m_valid_reg;
    logic [4:0] o_osr_reg;
    logic [11:0] o_div_reg;
    logic o_be_reg, o_fail_reg;
    logic [30:0] o_err_reg;

    assign ratio = {1'b0, osr_reg} + 6'd1;
    assign bmul = req_reg.baud * ratio;
    assign dmul = 36'(div_reg) * 36'(ratio);
    assign dv_den = (state_reg == S_DIV1) ? 36'(bmul) : dmul;
    assign err = (31'(req_reg.baud) > ach_reg) ? 31'(req_reg.baud) - ach_reg
                                               : ach_reg - 31'(req_reg.baud);
    assign q_ready = (state_reg == S_IDLE);
    assign dv_start = ((state_reg == S_DIV1) || (state_reg == S_DIV2)) && !dv_busy && !dv_done;

    ubds_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .dividend(req_reg.clk),
        .divisor(dv_den), .busy(dv_busy), .done(dv_done), .quotient(dv_q)
    );

    logic last_osr;
    assign last_osr = (osr_reg == OSR_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // In the emit state a taken result is replaced by the next one below.
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        req_reg <= q_req;
                        osr_reg <= OSR_FIRST;
                        found_reg <= 1'b0;
                        state_reg <= (q_req.baud == '0) ? S_EMIT : S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (dv_done) begin
                        div_reg <= dv_q;
                        // A zero divisor is skipped without the second division.
                        if (dv_q == '0) begin
                            if (last_osr) state_reg <= S_EMIT;
                            else osr_reg <= osr_reg + 5'd1;
                        end else begin
                            state_reg <= S_DIV2;
                        end
                    end
                end
                S_DIV2: begin
                    if (dv_done) begin
                        ach_reg <= dv_q;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if ((div_reg < (31'd1 << DIVISOR_BITS)) &&
                        (!found_reg || err < best_err_reg)) begin
                        found_reg <= 1'b1;
                        best_osr_reg <= osr_reg;
                        best_div_reg <= div_reg[DIVISOR_BITS-1:0];
                        best_err_reg <= err;
                    end
                    if (last_osr) state_reg <= S_EMIT;
                    else begin
                        osr_reg <= osr_reg + 5'd1;
                        state_reg <= S_DIV1;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        o_fail_reg <= !found_reg;
                        o_osr_reg <= found_reg ? best_osr_reg : '0;
                        o_div_reg <= found_reg ? 12'(best_div_reg) : '0;
                        o_err_reg <= found_reg ? best_err_reg : '0;
                        o_be_reg <= found_reg && (best_osr_reg >= 5'd3) && (best_osr_reg <= 5'd6);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_oversample = o_osr_reg;
    assign m_divisor = o_div_reg;
    assign m_both_edge = o_be_reg;
    assign m_rate_error = o_err_reg;
    assign m_failed = o_fail_reg;

    fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_failed) |-> (m_divisor == '0 && m_oversample == '0))
        else $error("failed result carries data");
    osr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_failed) |-> (m_oversample >= OSR_FIRST))
        else $error("oversampling below range");
    take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> (state_reg != S_IDLE))
        else $error("request taken without starting");
endmodule

// ----- rtl/uart_baud_divisor_search_core.sv -----
// Channel   | Direction | Handshake          | Payload
// request   | in        | s_valid / s_ready  | s_baud_rate
// result    | out       | m_valid / m_ready  | m_oversample, m_divisor, m_both_edge,
//           |           |                    | m_rate_error, m_failed
// Each request runs two serial divisions on the shared divider and a compare per
// oversample setting 3 to 31; a zero quotient skips the rest, zero baud skips it all.
// Reset is synchronous and active low; the clock register returns to 48 MHz.
// A two-entry queue accepts requests while the search runs or a result stalls.
module uart_baud_divisor_search_core #(
    parameter int DIVISOR_BITS = ubds_pkg::DIVISOR_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [23:0] s_baud_rate,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_oversample,
    output logic [11:0] m_divisor,
    output logic        m_both_edge,
    output logic [30:0] m_rate_error,
    output logic        m_failed
);
    import ubds_pkg::*;

    logic q_valid, q_ready;
    ubds_req_t q_req;

    ubds_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_baud_rate(s_baud_rate),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    ubds_search #(.DIVISOR_BITS(DIVISOR_BITS)) u_search (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_req(q_req), .m_valid(m_valid), .m_ready(m_ready),
        .m_oversample(m_oversample), .m_divisor(m_divisor), .m_both_edge(m_both_edge),
        .m_rate_error(m_rate_error), .m_failed(m_failed)
    );
endmodule
